// ===== hdl/sams_pkg.sv =====
// Shared types and constants for the stepper angle move sequencer.
// No dependencies; every other file in hdl/ uses this package.
`timescale 1ns / 1ps

package sams_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_POWERUP    = 3'd0;
    localparam logic [2:0] CFG_STEP_HIGH  = 3'd1;
    localparam logic [2:0] CFG_STEP_LOW   = 3'd2;
    localparam logic [2:0] CFG_SETTLE     = 3'd3;
    localparam logic [2:0] CFG_STEPS_DEG  = 3'd4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int TICK_W     = 16;
    localparam int SPD_W      = 5;
    localparam int ANGLE_W    = 8;
    localparam int STEPS_W    = 12;

    // Register reset values
    localparam logic [TICK_W-1:0] RST_POWERUP   = 16'd10000;
    localparam logic [TICK_W-1:0] RST_STEP_HIGH = 16'd50;
    localparam logic [TICK_W-1:0] RST_STEP_LOW  = 16'd360;
    localparam logic [TICK_W-1:0] RST_SETTLE    = 16'd50;
    localparam logic [SPD_W-1:0]  RST_STEPS_DEG = 5'd6;

    localparam logic [SPD_W-1:0]   SPD_LIMIT   = 5'd16;
    localparam logic [STEPS_W-1:0] STEPS_LIMIT = '1;

    // Operation codes of an input word
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    typedef struct packed {
        logic               op;
        logic [ANGLE_W-1:0] degrees;
    } t_in_word;

    typedef struct packed {
        logic               motor_power;
        logic               enable_n;
        logic               direction;
        logic               step;
        logic               busy_res;
        logic [ANGLE_W-1:0] position;
        logic               rejected;
    } t_out_word;

endpackage

// ===== hdl/sams_in_if.sv =====
// Request channel: valid/ready handshake carrying one input word.
// Depends on sams_pkg.
`timescale 1ns / 1ps

interface sams_in_if;
    logic               valid;
    logic               ready;
    sams_pkg::t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/sams_out_if.sv =====
// Result channel: valid/ready handshake carrying one result word.
// Depends on sams_pkg.
`timescale 1ns / 1ps

interface sams_out_if;
    logic                valid;
    logic                ready;
    sams_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/stepper_angle_move_sequencer.sv =====
// Stepper angle move sequencer: top level, single module.
// Depends on sams_pkg, sams_in_if and sams_out_if.
`timescale 1ns / 1ps

// The block takes one input word per cycle: either a one-microsecond tick or an angle
// request (0..MAX_ANGLE degrees; anything larger is flagged as rejected and dropped).
// Every accepted word yields exactly one result word with the pin levels after it:
// motor power, active-low driver enable, direction, step level, busy, the last
// completed angle and the reject flag. A move powers the motor, waits powerup_ticks,
// enables the driver, gives |target - angle| times the configured pulses-per-degree
// count (capped at 16) of pulses (step_high_ticks high, then
// step_low_ticks low), waits settle_ticks, then disables, powers down and takes the
// target as the new angle. A request during a move is held (latest wins) and starts
// when the move ends. Throughput is one word per clock: the sequencer state updates in
// the cycle a word is accepted and the result lands in a single output register, so
// i_req.ready stays high unless that register holds a word the sink has not taken.
// The user must write configuration through i_cfg_* only while idle; not enforced.
module stepper_angle_move_sequencer #(
    parameter int MAX_ANGLE  = 180,
    parameter int TIMER_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sams_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sams_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    sams_in_if.sink                           i_req,
    sams_out_if.source                        o_res
);

    localparam int CMP_W = (TIMER_BITS > sams_pkg::TICK_W) ? TIMER_BITS : sams_pkg::TICK_W;
    localparam int PROD_W = sams_pkg::ANGLE_W + sams_pkg::SPD_W;
    localparam logic [TIMER_BITS-1:0]         TMR_MAX   = '1;
    localparam logic [sams_pkg::ANGLE_W-1:0]  ANGLE_TOP = sams_pkg::ANGLE_W'(MAX_ANGLE);

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_POWERUP = 3'd1,
        PH_HIGH    = 3'd2,
        PH_LOW     = 3'd3,
        PH_SETTLE  = 3'd4
    } t_phase;

    // Configuration
    logic [sams_pkg::TICK_W-1:0]   r_powerup, r_step_high, r_step_low, r_settle;
    logic [sams_pkg::SPD_W-1:0]    r_spd;

    // Sequencer state
    t_phase                        r_phase, n_phase;
    logic [TIMER_BITS-1:0]         r_cnt, n_cnt;
    logic [sams_pkg::STEPS_W-1:0]  r_steps, n_steps;
    logic [sams_pkg::ANGLE_W-1:0]  r_cur, n_cur;
    logic [sams_pkg::ANGLE_W-1:0]  r_target, n_target;
    logic [sams_pkg::ANGLE_W-1:0]  r_pend, n_pend;
    logic                          r_pend_vld, n_pend_vld;
    logic                          r_dir, n_dir;

    // Output register
    logic                          r_out_vld;
    sams_pkg::t_out_word           r_out, n_out;

    logic                          in_acc;
    logic                          rejected;
    logic                          start;
    logic [TIMER_BITS-1:0]         cnt_inc;
    logic [sams_pkg::TICK_W-1:0]   ph_len;
    logic [CMP_W-1:0]              ph_lim;
    logic                          ph_done;
    logic [sams_pkg::STEPS_W-1:0]  steps_dec;
    logic [sams_pkg::ANGLE_W-1:0]  diff;
    logic [sams_pkg::SPD_W-1:0]    spd_eff;
    logic [PROD_W-1:0]             prod;

    // Output register frees up when empty or being drained.
    assign i_req.ready = !r_out_vld || o_res.ready;
    assign in_acc      = i_req.valid && i_req.ready;
    assign o_res.valid = r_out_vld;
    assign o_res.data  = r_out;

    // Timer: saturating count, phase ends once count reaches length (capped at max).
    assign cnt_inc = (r_cnt == TMR_MAX) ? r_cnt : r_cnt + 1'b1;

    always_comb begin
        case (r_phase)
            PH_POWERUP: ph_len = r_powerup;
            PH_HIGH:    ph_len = r_step_high;
            PH_LOW:     ph_len = r_step_low;
            default:    ph_len = r_settle;
        endcase
    end

    assign ph_lim  = (CMP_W'(ph_len) > CMP_W'(TMR_MAX)) ? CMP_W'(TMR_MAX) : CMP_W'(ph_len);
    assign ph_done = CMP_W'(cnt_inc) >= ph_lim;
    assign steps_dec = (r_steps != '0) ? r_steps - 1'b1 : r_steps;

    always_comb begin
        n_phase    = r_phase;
        n_cnt      = r_cnt;
        n_steps    = r_steps;
        n_cur      = r_cur;
        n_target   = r_target;
        n_pend     = r_pend;
        n_pend_vld = r_pend_vld;
        n_dir      = r_dir;
        rejected   = 1'b0;
        start      = 1'b0;
        diff       = '0;
        spd_eff    = '0;
        prod       = '0;

        if (i_req.data.op == sams_pkg::OP_REQUEST) begin
            if (i_req.data.degrees > ANGLE_TOP) begin
                rejected = 1'b1;
            end else begin
                n_pend     = i_req.data.degrees;
                n_pend_vld = 1'b1;
                start      = (r_phase == PH_IDLE);
            end
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                    n_phase = PH_IDLE;
                end
                PH_POWERUP: begin
                    n_cnt = ph_done ? '0 : cnt_inc;
                    if (ph_done) begin
                        n_phase = (r_steps != '0) ? PH_HIGH : PH_SETTLE;
                    end
                end
                PH_HIGH: begin
                    n_cnt = ph_done ? '0 : cnt_inc;
                    if (ph_done) begin
                        n_phase = PH_LOW;
                    end
                end
                PH_LOW: begin
                    n_cnt = ph_done ? '0 : cnt_inc;
                    if (ph_done) begin
                        n_steps = steps_dec;
                        n_phase = (steps_dec != '0) ? PH_HIGH : PH_SETTLE;
                    end
                end
                PH_SETTLE: begin
                    n_cnt = ph_done ? '0 : cnt_inc;
                    if (ph_done) begin
                        n_cur   = r_target;
                        n_phase = PH_IDLE;
                        start   = r_pend_vld;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end

        // Launch the held request; equal target is consumed with no activity.
        if (start) begin
            n_pend_vld = 1'b0;
            n_target   = n_pend;
            if (n_pend != n_cur) begin
                n_dir   = n_pend > n_cur;
                diff    = n_dir ? n_pend - n_cur : n_cur - n_pend;
                spd_eff = (r_spd > sams_pkg::SPD_LIMIT) ? sams_pkg::SPD_LIMIT : r_spd;
                prod    = PROD_W'(diff) * PROD_W'(spd_eff);
                n_steps = (prod > PROD_W'(sams_pkg::STEPS_LIMIT))
                          ? sams_pkg::STEPS_LIMIT : prod[sams_pkg::STEPS_W-1:0];
                n_cnt   = '0;
                n_phase = PH_POWERUP;
            end
        end

        n_out.motor_power = (n_phase != PH_IDLE);
        n_out.enable_n    = !((n_phase == PH_HIGH) || (n_phase == PH_LOW)
                              || (n_phase == PH_SETTLE));
        n_out.direction   = n_dir;
        n_out.step        = (n_phase == PH_HIGH);
        n_out.busy_res    = (n_phase != PH_IDLE);
        n_out.position    = n_cur;
        n_out.rejected    = rejected;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_powerup   <= sams_pkg::RST_POWERUP;
            r_step_high <= sams_pkg::RST_STEP_HIGH;
            r_step_low  <= sams_pkg::RST_STEP_LOW;
            r_settle    <= sams_pkg::RST_SETTLE;
            r_spd       <= sams_pkg::RST_STEPS_DEG;
            r_phase     <= PH_IDLE;
            r_cnt       <= '0;
            r_steps     <= '0;
            r_cur       <= '0;
            r_target    <= '0;
            r_pend      <= '0;
            r_pend_vld  <= 1'b0;
            r_dir       <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    sams_pkg::CFG_POWERUP:   r_powerup   <= i_cfg_data;
                    sams_pkg::CFG_STEP_HIGH: r_step_high <= i_cfg_data;
                    sams_pkg::CFG_STEP_LOW:  r_step_low  <= i_cfg_data;
                    sams_pkg::CFG_SETTLE:    r_settle    <= i_cfg_data;
                    sams_pkg::CFG_STEPS_DEG: r_spd       <= i_cfg_data[sams_pkg::SPD_W-1:0];
                    default: ;
                endcase
            end
            if (in_acc) begin
                r_phase    <= n_phase;
                r_cnt      <= n_cnt;
                r_steps    <= n_steps;
                r_cur      <= n_cur;
                r_target   <= n_target;
                r_pend     <= n_pend;
                r_pend_vld <= n_pend_vld;
                r_dir      <= n_dir;
                r_out      <= n_out;
                r_out_vld  <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld  <= 1'b0;
            end
        end
    end

    // A step pulse only ever goes out with the driver powered and enabled.
    a_step_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (!r_out.step || (!r_out.enable_n && r_out.motor_power)))
        else $error("step high while driver not enabled");

    // Idle implies a cleared tick counter.
    a_idle_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_cnt == '0))
        else $error("tick counter nonzero while idle");

    // A rejected request leaves the sequencer untouched.
    a_reject_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_req.data.op == sams_pkg::OP_REQUEST)
         && (i_req.data.degrees > ANGLE_TOP))
        |=> ((r_phase == $past(r_phase)) && (r_cur == $past(r_cur))
             && (r_pend_vld == $past(r_pend_vld)) && r_out.rejected))
        else $error("rejected request changed state");

    // No new word lands while a result waits unaccepted.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_res.ready) |=> (r_out_vld && $stable(r_out)))
        else $error("pending result overwritten");

endmodule
